// ===== rtl/fcu_pkg.sv =====
// ----------------------------------------------------------------------------
// fcu_pkg: shared types and codes of the font code to UTF-8 transcoder
// Holds the register map, mode and operation codes and the queue entry type.
// ----------------------------------------------------------------------------
package fcu_pkg;

    // Operation codes of an input beat.
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_TEXT_BYTE   = 1'b1;

    // Encoding modes held in the mode register. The spare code acts as passthrough.
    localparam logic [1:0] MODE_PASSTHROUGH = 2'd0;
    localparam logic [1:0] MODE_TABLE       = 2'd1;
    localparam logic [1:0] MODE_IDENTITY    = 2'd2;

    // Register map (word index taken from the byte address).
    localparam logic REG_ENCODING_MODE = 1'b0;

    // Bus widths of the configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // One decoded code value on its way to the UTF-8 serializer.
    typedef struct packed {
        logic        raw;    // copy the low byte unchanged
        logic [15:0] value;  // code value or raw byte
    } t_q_entry;

endpackage

// ===== rtl/font_code_to_utf8_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// font_code_to_utf8_transcoder_core: font character codes to UTF-8 bytes
// Input beats are taken one per cycle while the queue has room; the output
// runs one byte per cycle while the receiver is ready, and a code value
// becomes one to three bytes at the UTF-8 serializer.
// Reset (synchronous, active low) clears the mode register to passthrough, the
// pending identity byte, the queue and the per-entry valid bits of the table.
// ----------------------------------------------------------------------------
module font_code_to_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcu_pkg::ADDR_W-1:0]   paddr,
    input  logic [fcu_pkg::DATA_W-1:0]   pwdata,
    output logic [fcu_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic [7:0]                   i_code_byte,
    input  logic                         i_text_end,
    input  logic [7:0]                   i_entry_index,
    input  logic [15:0]                  i_entry_value,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_utf8_byte,
    output logic                         o_run_last
);

    // The mode register sits at byte address 0; address bit 2 selects the
    // word, so a write to the upper word is taken on the bus and ignored.
    logic [1:0]        r_mode;
    logic              reg_sel;

    logic              push;
    fcu_pkg::t_q_entry push_entry;
    logic              q_full;
    logic              q_valid;
    fcu_pkg::t_q_entry q_head;
    logic              pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == fcu_pkg::REG_ENCODING_MODE);
    assign prdata  = reg_sel ? {{(fcu_pkg::DATA_W - 2){1'b0}}, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fcu_pkg::MODE_PASSTHROUGH;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_mode <= pwdata[1:0];
        end
    end

    // Front: takes every input beat. Table writes and the first byte of an
    // identity pair finish here; the rest leave as code values after the
    // registered table read.
    fcu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (r_mode),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_code_byte   (i_code_byte),
        .i_text_end    (i_text_end),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_push_entry  (push_entry)
    );

    // The queue lets the front keep accepting while a three-byte sequence
    // drains at the back.
    fcu_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_valid      (q_valid),
        .o_head       (q_head)
    );

    // Back: splits each code value into its UTF-8 bytes, one beat per cycle while
    // the receiver is ready, marking the final byte of each value.
    fcu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_utf8_byte (o_utf8_byte),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== rtl/fcu_front.sv =====
// ----------------------------------------------------------------------------
// fcu_front: accept and classify input beats
// Loads the code table, pairs identity bytes and looks up table codes.
// ----------------------------------------------------------------------------
module fcu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_mode,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [7:0]         i_code_byte,
    input  logic               i_text_end,
    input  logic [7:0]         i_entry_index,
    input  logic [15:0]        i_entry_value,
    input  logic               i_q_full,
    output logic               o_push,
    output fcu_pkg::t_q_entry  o_push_entry
);

    logic [15:0]       r_table [256];
    logic [255:0]      r_entry_valid;
    logic [15:0]       r_rd_data;
    logic              r_rd_hit;
    logic              r_s1_valid;
    logic              r_s1_table;
    fcu_pkg::t_q_entry r_s1_entry;
    logic [7:0]        r_pending_byte;
    logic              r_pending_valid;

    logic              s1_adv;
    logic              fire;
    logic              is_text;
    logic              produce;
    logic              use_table;
    fcu_pkg::t_q_entry n_entry;
    logic              n_pending_valid;

    assign s1_adv     = !r_s1_valid || !i_q_full;
    assign o_in_ready = s1_adv;
    assign fire       = i_in_valid && s1_adv;
    assign is_text    = (i_op == fcu_pkg::OP_TEXT_BYTE);

    always_comb begin
        produce         = 1'b0;
        use_table       = 1'b0;
        n_entry.raw     = 1'b0;
        n_entry.value   = {8'h00, i_code_byte};
        n_pending_valid = r_pending_valid;
        unique case (i_mode)
            fcu_pkg::MODE_TABLE: begin
                produce   = 1'b1;
                use_table = 1'b1;
            end
            fcu_pkg::MODE_IDENTITY: begin
                if (r_pending_valid) begin
                    produce         = 1'b1;
                    n_entry.value   = {i_code_byte, r_pending_byte};
                    n_pending_valid = 1'b0;
                end else if (!i_text_end) begin
                    n_pending_valid = 1'b1;
                end
            end
            default: begin
                produce     = 1'b1;
                n_entry.raw = 1'b1;
            end
        endcase
        if (i_text_end) begin
            n_pending_valid = 1'b0;
        end
    end

    // Table store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (fire && !is_text) begin
            r_table[i_entry_index] <= i_entry_value;
        end
        if (fire && is_text && use_table) begin
            r_rd_data <= r_table[i_code_byte];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid   <= '0;
            r_rd_hit        <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_pending_valid <= 1'b0;
        end else begin
            if (fire && !is_text) begin
                r_entry_valid[i_entry_index] <= 1'b1;
            end
            if (fire && is_text) begin
                r_pending_valid <= n_pending_valid;
                if (use_table) begin
                    r_rd_hit <= r_entry_valid[i_code_byte];
                end
            end
            if (s1_adv) begin
                r_s1_valid <= fire && is_text && produce;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_text) begin
            if (!r_pending_valid) begin
                r_pending_byte <= i_code_byte;
            end
            if (s1_adv) begin
                r_s1_table <= use_table;
                r_s1_entry <= n_entry;
            end
        end
    end

    assign o_push             = r_s1_valid && !i_q_full;
    assign o_push_entry.raw   = r_s1_entry.raw && !r_s1_table;
    assign o_push_entry.value = r_s1_table ? (r_rd_hit ? r_rd_data : 16'h0000)
                                           : r_s1_entry.value;

endmodule

// ===== rtl/fcu_queue.sv =====
// ----------------------------------------------------------------------------
// fcu_queue: short queue between front and back
// A small first-in first-out buffer of decoded code values.
// ----------------------------------------------------------------------------
module fcu_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fcu_pkg::t_q_entry  i_push_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output fcu_pkg::t_q_entry  o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    fcu_pkg::t_q_entry r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fcu_back.sv =====
// ----------------------------------------------------------------------------
// fcu_back: UTF-8 serializer
// Emits one to three bytes per code value through a registered output.
// ----------------------------------------------------------------------------
module fcu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  fcu_pkg::t_q_entry  i_q_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_utf8_byte,
    output logic               o_run_last
);

    logic              r_cur_valid;
    fcu_pkg::t_q_entry r_cur;
    logic [1:0]        r_pos;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic [1:0]        len;
    logic [7:0]        byte_sel;
    logic              cur_last;
    logic              load_out;

    always_comb begin
        if (r_cur.raw || (r_cur.value[15:7] == '0)) begin
            len = 2'd1;
        end else if (r_cur.value[15:11] == '0) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
    end

    always_comb begin
        byte_sel = {2'b10, r_cur.value[5:0]};
        case (len)
            2'd1: byte_sel = r_cur.raw ? r_cur.value[7:0] : {1'b0, r_cur.value[6:0]};
            2'd2: begin
                if (r_pos == 2'd0) begin
                    byte_sel = {3'b110, r_cur.value[10:6]};
                end
            end
            default: begin
                if (r_pos == 2'd0) begin
                    byte_sel = {4'b1110, r_cur.value[15:12]};
                end else if (r_pos == 2'd1) begin
                    byte_sel = {2'b10, r_cur.value[11:6]};
                end
            end
        endcase
    end

    assign cur_last = (r_pos == len - 2'd1);
    assign load_out = r_cur_valid && (!r_out_valid || i_out_ready);
    assign o_pop    = i_q_valid && (!r_cur_valid || (load_out && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 2'd0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_pos       <= 2'd0;
            end else if (load_out) begin
                if (cur_last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_head;
        end
        if (load_out) begin
            r_out_byte <= byte_sel;
            r_out_last <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_utf8_byte = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the font code to UTF-8 transcoder core
// A short table of hand-picked beats covers the register extremes, table loads,
// every encoding mode and the odd cases of identity byte pairing. Random phases
// follow: each one sets a mode over the configuration port, then streams table
// loads and text bytes while both channels stall at random. Every output byte is
// compared with a transcoding model that the bench keeps alongside the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    // The spare mode code. The core treats it as passthrough.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_BEATS    = 37;
    localparam int IDLE_TAIL      = 8;    // lets a beat that emits nothing leave the core
    localparam int LONG_HOLD      = 80;   // receiver hold-off that fills the queue
    localparam int MAX_REPORTS    = 10;

    // One input beat as the sender holds it. When has_typed is set, the bytes in
    // typed_byte (first byte at index 0) are expected instead of the model's.
    typedef struct packed {
        logic        op;
        logic [7:0]  code_byte;
        logic        text_end;
        logic [7:0]  entry_index;
        logic [15:0] entry_value;
        logic        has_typed;
        logic [1:0]  typed_cnt;
        logic [2:0][7:0] typed_byte;
    } t_beat;

    // One row of the directed table: the mode to run it in, the beat, and the
    // output bytes in the order they leave the core.
    typedef struct packed {
        logic [1:0]  mode;
        logic        op;
        logic [7:0]  code_byte;
        logic        text_end;
        logic [7:0]  entry_index;
        logic [15:0] entry_value;
        logic        typed;
        logic [1:0]  n;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
    } t_directed_row;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       run_last;
    } t_out_byte;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the core. Every input starts known.
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [fcu_pkg::ADDR_W-1:0]  paddr   = '0;
    logic [fcu_pkg::DATA_W-1:0]  pwdata  = '0;
    logic [fcu_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    t_beat       tx_beat    = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op;
    logic [7:0]  i_code_byte;
    logic        i_text_end;
    logic [7:0]  i_entry_index;
    logic [15:0] i_entry_value;

    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_utf8_byte;
    logic        o_run_last;

    // The payload ports follow the beat register, which is only ever written
    // with nonblocking assignments at a rising edge.
    assign i_op          = tx_beat.op;
    assign i_code_byte   = tx_beat.code_byte;
    assign i_text_end    = tx_beat.text_end;
    assign i_entry_index = tx_beat.entry_index;
    assign i_entry_value = tx_beat.entry_value;

    font_code_to_utf8_transcoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_code_byte   (i_code_byte),
        .i_text_end    (i_text_end),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_utf8_byte   (o_utf8_byte),
        .o_run_last    (o_run_last)
    );

    // ------------------------------------------------------------------------
    // Transcoding model. Its state mirrors the core: the code store (all zero
    // after reset), the held low byte of an identity pair and the mode.
    // ------------------------------------------------------------------------
    logic [15:0] code_store [256] = '{default: 16'h0000};
    logic [7:0]  held_low_byte    = 8'h00;
    logic        held_valid       = 1'b0;
    logic [1:0]  mode_model       = fcu_pkg::MODE_PASSTHROUGH;

    t_out_byte   utf8_due [$];          // output bytes still to come, oldest first
    int          mismatch_count = 0;

    function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    // UTF-8 form of one 16-bit code value. Surrogates get no special treatment,
    // they simply come out as three-byte sequences.
    function automatic int utf8_encode(input logic [15:0] v, output logic [2:0][7:0] bytes);
        bytes = '0;
        if (v < 16'h0080) begin
            bytes[0] = v[7:0];
            return 1;
        end else if (v < 16'h0800) begin
            bytes[0] = {3'b110, v[10:6]};
            bytes[1] = {2'b10, v[5:0]};
            return 2;
        end
        bytes[0] = {4'b1110, v[15:12]};
        bytes[1] = {2'b10, v[11:6]};
        bytes[2] = {2'b10, v[5:0]};
        return 3;
    endfunction

    // Advance the model by one accepted beat and return the bytes it emits.
    function automatic void transcode_beat(input t_beat b, output logic [2:0][7:0] bytes,
                                           output int n);
        bytes = '0;
        n     = 0;
        if (b.op == fcu_pkg::OP_TABLE_WRITE) begin
            // A table load emits nothing and leaves a held identity byte alone.
            code_store[b.entry_index] = b.entry_value;
        end else begin
            case (mode_model)
                fcu_pkg::MODE_TABLE: begin
                    n = utf8_encode(code_store[b.code_byte], bytes);
                end
                fcu_pkg::MODE_IDENTITY: begin
                    if (held_valid) begin
                        n = utf8_encode({b.code_byte, held_low_byte}, bytes);
                        held_valid = 1'b0;
                    end else if (!b.text_end) begin
                        held_low_byte = b.code_byte;
                        held_valid    = 1'b1;
                    end
                    // A lone first byte that ends the string is simply dropped.
                end
                default: begin
                    // Passthrough, and the spare code that behaves the same.
                    bytes[0] = b.code_byte;
                    n        = 1;
                end
            endcase
            // The end of a string never leaves half a pair behind, in any mode.
            if (b.text_end)
                held_valid = 1'b0;
        end
    endfunction

    function automatic void queue_run(input logic [2:0][7:0] bytes, input int n);
        t_out_byte ob;
        for (int k = 0; k < n; k++) begin
            ob.utf8_byte = bytes[k];
            ob.run_last  = (k == n - 1);
            utf8_due.insert(utf8_due.size(), ob);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the core's own
    // updates of that edge land, so the order of processes does not matter.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [2:0][7:0] run_bytes;
        int              run_len;
        t_out_byte       due;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready
                && paddr[2] == fcu_pkg::REG_ENCODING_MODE)
                mode_model = pwdata[1:0];

            if (i_in_valid && o_in_ready) begin
                transcode_beat(tx_beat, run_bytes, run_len);
                if (tx_beat.has_typed)
                    queue_run(tx_beat.typed_byte, int'(tx_beat.typed_cnt));
                else
                    queue_run(run_bytes, run_len);
            end

            if (o_out_valid && i_out_ready) begin
                if (utf8_due.size() == 0) begin
                    flag_mismatch("output beat with nothing expected", 32'h0,
                                  32'({o_run_last, o_utf8_byte}));
                end else begin
                    due = utf8_due.pop_front();
                    if (o_utf8_byte !== due.utf8_byte)
                        flag_mismatch("utf8_byte", 32'(due.utf8_byte), 32'(o_utf8_byte));
                    if (o_run_last !== due.run_last)
                        flag_mismatch("run_last", 32'(due.run_last), 32'(o_run_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It alternates runs of ready and stall of random length, long
    // ready runs included. On request it holds off for a counted stretch so
    // that the core's queue fills and the input side has to stall.
    // ------------------------------------------------------------------------
    int hold_request = 0;

    initial begin
        int run;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                run          = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 4) < 3) begin
                run          = $urandom_range(1, 20);
                i_out_ready <= 1'b1;
            end else begin
                run          = $urandom_range(1, 6);
                i_out_ready <= 1'b0;
            end
            repeat (run) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Beats go out in bursts of random length with random gaps; in a
    // steady phase the gaps are zero. Valid stays up between beats of a burst.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    bit tx_steady  = 1'b0;

    task automatic send_beat(input t_beat b);
        int gap;
        if (burst_left == 0) begin
            gap = tx_steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        tx_beat    <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop offering beats and wait until every expected byte has come out, then
    // wait out the idle tail so that a beat that emits nothing leaves the pipeline.
    task automatic wait_drained();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (utf8_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // Mode register write followed by a read back. Only called while idle.
    logic [1:0] cfg_mode = fcu_pkg::MODE_PASSTHROUGH;

    task automatic set_encoding_mode(input logic [1:0] m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {fcu_pkg::REG_ENCODING_MODE, 2'b00};
        pwdata  <= fcu_pkg::DATA_W'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // Write lands at the edge above; the read setup keeps psel high.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[1:0] !== m)
            flag_mismatch("encoding_mode read back", 32'(m), 32'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_mode = m;
    endtask

    // A code value spread over all UTF-8 lengths, surrogates and the edges
    // between the length classes.
    function automatic logic [15:0] rand_code_value();
        logic [15:0] boundary [6] = '{16'h0000, 16'h007F, 16'h0080,
                                      16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDFFF));
            default: return boundary[$urandom_range(0, 5)];
        endcase
    endfunction

    // A text beat with every field random; unused fields toggle too.
    function automatic t_beat random_beat();
        t_beat b;
        b             = '0;
        b.op          = fcu_pkg::OP_TEXT_BYTE;
        b.code_byte   = 8'($urandom);
        b.text_end    = ($urandom_range(0, 3) == 0);
        b.entry_index = 8'($urandom);
        b.entry_value = 16'($urandom);
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. The first block loads the store with the edges of each
    // UTF-8 length class and a surrogate; table mode then reads them back.
    // The identity rows cover a table load between the two bytes of a pair, an
    // odd final byte, and a held byte that survives a trip through passthrough
    // (those two rows are left to the model). The spare mode closes the table.
    // ------------------------------------------------------------------------
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TEXT_BYTE, 8'h00, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TEXT_BYTE, 8'hFF, 1'b1, 8'hFF, 16'hFFFF,
          1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TABLE_WRITE, 8'hFF, 1'b1, 8'hFF, 16'hFFFF,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TABLE_WRITE, 8'h00, 1'b0, 8'h41, 16'h007F,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TABLE_WRITE, 8'h00, 1'b0, 8'h42, 16'h0080,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TABLE_WRITE, 8'h00, 1'b0, 8'h43, 16'h07FF,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TABLE_WRITE, 8'h00, 1'b0, 8'h44, 16'h0800,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TABLE_WRITE, 8'h00, 1'b0, 8'h45, 16'hD800,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'hFF, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd3, 8'hEF, 8'hBF, 8'hBF},
        // Entry zero was never loaded: a zero code value is one zero byte.
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'h00, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'h41, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd1, 8'h7F, 8'h00, 8'h00},
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'h42, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd2, 8'hC2, 8'h80, 8'h00},
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'h43, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd2, 8'hDF, 8'hBF, 8'h00},
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'h44, 1'b1, 8'h00, 16'h0000,
          1'b1, 2'd3, 8'hE0, 8'hA0, 8'h80},
        '{fcu_pkg::MODE_TABLE, fcu_pkg::OP_TEXT_BYTE, 8'h45, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd3, 8'hED, 8'hA0, 8'h80},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'h34, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TABLE_WRITE, 8'h00, 1'b0, 8'h10, 16'h1234,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'h12, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd3, 8'hE1, 8'h88, 8'hB4},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'h7F, 1'b1, 8'h00, 16'h0000,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'hFF, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'hFF, 1'b1, 8'h00, 16'h0000,
          1'b1, 2'd3, 8'hEF, 8'hBF, 8'hBF},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'h56, 1'b0, 8'h00, 16'h0000,
          1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_PASSTHROUGH, fcu_pkg::OP_TEXT_BYTE, 8'h99, 1'b0, 8'h00, 16'h0000,
          1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{fcu_pkg::MODE_IDENTITY, fcu_pkg::OP_TEXT_BYTE, 8'h00, 1'b1, 8'h00, 16'h0000,
          1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{MODE_SPARE, fcu_pkg::OP_TEXT_BYTE, 8'hA5, 1'b1, 8'h00, 16'h0000,
          1'b1, 2'd1, 8'hA5, 8'h00, 8'h00}
    };

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain and verdict.
    // ------------------------------------------------------------------------
    initial begin
        t_directed_row row;
        t_beat         b;
        logic [15:0]   v;
        logic [1:0]    next_mode;
        int            sent;
        bit            paused;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            if (row.mode != cfg_mode) begin
                wait_drained();
                set_encoding_mode(row.mode);
            end
            b             = '0;
            b.op          = row.op;
            b.code_byte   = row.code_byte;
            b.text_end    = row.text_end;
            b.entry_index = row.entry_index;
            b.entry_value = row.entry_value;
            b.has_typed   = row.typed;
            b.typed_cnt   = row.n;
            b.typed_byte  = {row.b2, row.b1, row.b0};
            send_beat(b);
        end

        // The first four phases visit every mode code, later ones lean toward
        // the two modes that do real work. Phase 1 pauses halfway until the
        // core is empty; phase 2 streams without gaps into a long hold-off.
        paused = 1'b0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: next_mode = fcu_pkg::MODE_TABLE;
                1: next_mode = fcu_pkg::MODE_IDENTITY;
                2: next_mode = fcu_pkg::MODE_PASSTHROUGH;
                3: next_mode = MODE_SPARE;
                default: begin
                    if ($urandom_range(0, 2) != 0)
                        next_mode = $urandom_range(0, 1) ? fcu_pkg::MODE_TABLE
                                                         : fcu_pkg::MODE_IDENTITY;
                    else
                        next_mode = 2'($urandom_range(0, 3));
                end
            endcase
            wait_drained();
            set_encoding_mode(next_mode);
            tx_steady = (p % 3 == 2);
            if (p == 2)
                hold_request = LONG_HOLD;

            sent = 0;
            while (sent < PHASE_BEATS) begin
                if (p == 1 && !paused && sent >= PHASE_BEATS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                b = random_beat();
                if ($urandom_range(0, 5) == 0) begin
                    // Table loads land in a small window half the time so that
                    // table-mode reads hit loaded entries often.
                    b.op          = fcu_pkg::OP_TABLE_WRITE;
                    b.entry_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                         : 8'($urandom);
                    b.entry_value = rand_code_value();
                    send_beat(b);
                    sent++;
                end else if (next_mode == fcu_pkg::MODE_IDENTITY
                             && $urandom_range(0, 4) != 0) begin
                    // A well-formed pair: low byte first, then the high byte,
                    // which may or may not end the string.
                    v          = rand_code_value();
                    b.code_byte = v[7:0];
                    b.text_end = 1'b0;
                    send_beat(b);
                    b           = random_beat();
                    b.code_byte = v[15:8];
                    b.text_end  = ($urandom_range(0, 2) == 0);
                    send_beat(b);
                    sent += 2;
                end else begin
                    // Single text bytes; in identity mode these break the
                    // pairing on purpose.
                    if (next_mode == fcu_pkg::MODE_TABLE && $urandom_range(0, 1))
                        b.code_byte = 8'($urandom_range(0, 15));
                    send_beat(b);
                    sent++;
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0 && utf8_due.size() == 0)
            $display("font_code_to_utf8_transcoder_core: match");
        else
            $display("font_code_to_utf8_transcoder_core: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("font_code_to_utf8_transcoder_core: mismatch");
        $finish;
    end

endmodule
